// File: design/bms_pkg.sv
// Shared types, codes and constants for the battery monitor frame receiver.
// No dependencies.
`default_nettype none

package bms_pkg;

  localparam int FRAME_BYTES = 128;
  localparam int MAX_SENSORS = 4;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int EXP_W       = 9;
  localparam int SENS_W      = $clog2(MAX_SENSORS + 1);

  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] END_BYTE   = 8'h77;
  localparam logic [7:0] CMD_LOW    = 8'h03;
  localparam logic [7:0] CMD_HIGH   = 8'h29;
  localparam logic [7:0] CMD_STATUS = 8'h03;
  localparam logic [7:0] CMD_CELL   = 8'h04;

  localparam logic [3:0] Q_VOLT    = 4'd0;
  localparam logic [3:0] Q_CURR    = 4'd1;
  localparam logic [3:0] Q_CAP_REM = 4'd2;
  localparam logic [3:0] Q_CAP_TYP = 4'd3;
  localparam logic [3:0] Q_CYCLES  = 4'd4;
  localparam logic [3:0] Q_PROTECT = 4'd5;
  localparam logic [3:0] Q_PERCENT = 4'd6;
  localparam logic [3:0] Q_CELLS   = 4'd7;
  localparam logic [3:0] Q_NTCS    = 4'd8;
  localparam logic [3:0] Q_TEMP    = 4'd9;
  localparam logic [3:0] Q_LOW     = 4'd10;
  localparam logic [3:0] Q_HIGH    = 4'd11;
  localparam logic [3:0] Q_DELTA   = 4'd12;
  localparam logic [3:0] Q_PARAM   = 4'd13;
  localparam logic [3:0] Q_CKERR   = 4'd14;
  localparam logic [3:0] Q_OVERRUN = 4'd15;

  // status frame walk: steps 0..8 map straight onto quantities 0..8
  localparam logic [3:0] STAT_NTC_STEP  = 4'd8;
  localparam logic [3:0] STAT_TEMP_STEP = 4'd9;
  localparam logic [3:0] STAT_CURR_STEP = 4'd1;
  localparam logic [3:0] STAT_PCT_STEP  = 4'd6;
  localparam logic [3:0] STAT_CELL_STEP = 4'd7;
  localparam int         TEMP_BASE      = 27;
  localparam int         DATA_BASE      = 4;

  localparam logic [16:0] KELVIN_OFS  = 17'd2731;
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam logic [15:0] CELL_START  = 16'd10000;

  typedef enum logic [2:0] {
    P_IDLE, P_START, P_PARAM, P_STATUS, P_CELL
  } phase_t;

  typedef enum logic [3:0] {
    S_RX, S_SUM_RD, S_SUM_ACC, S_WHI_RD, S_WHI, S_WLO, S_ACT,
    S_MUL, S_DIV, S_COUT, S_EMIT, S_NEXT
  } state_t;

  typedef enum logic [2:0] {
    J_CK, J_STAT, J_CELL, J_COUT, J_PARAM
  } job_t;

  // word position of each status reading; byte fields read the word around them
  function automatic logic [ADDR_W-1:0] stat_addr(input logic [3:0] step);
    logic [ADDR_W-1:0] a;
    case (step)
      4'd0:    a = ADDR_W'(4);
      4'd1:    a = ADDR_W'(6);
      4'd2:    a = ADDR_W'(8);
      4'd3:    a = ADDR_W'(10);
      4'd4:    a = ADDR_W'(12);
      4'd5:    a = ADDR_W'(20);
      4'd6:    a = ADDR_W'(22);
      4'd7:    a = ADDR_W'(24);
      4'd8:    a = ADDR_W'(26);
      default: a = ADDR_W'(TEMP_BASE);
    endcase
    return a;
  endfunction

  function automatic logic is_temp_code(input logic [7:0] c);
    return c inside {8'h19, 8'h1B, 8'h1D, 8'h1F};
  endfunction

  function automatic logic is_plain_code(input logic [7:0] c);
    return c inside {8'h20, 8'h21, 8'h23, 8'h25, 8'h27, 8'h28, 8'h29};
  endfunction

endpackage

`default_nettype wire

// File: design/bms_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module bms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/bms_frame_receiver.sv
// Battery monitor frame receiver: byte capture into a frame store, then a
// sequencer that walks the store to check the sum and produce readings.
// Depends on bms_pkg and bms_ram.
//
//   channel | ports            | payload
//   --------+------------------+-------------------------------------------
//   in      | in_t*            | rx_byte
//   out     | out_t*           | quantity, item_index, reading, last (tlast)
//
// A byte is taken while no frame is being evaluated and the result
// register is empty. On the end byte the sequencer reads the store one
// byte at a time through the RAM read port: it sums n - 5 bytes, then
// reads each word high byte first and passes each result through S_EMIT
// (S_COUT first for the cell results, S_MUL and S_DIV for a degree
// conversion). Reset (rst_n low, synchronous) returns to idle and marks
// the store empty. A stalled result holds the sequencer until it is taken.
`default_nettype none

module bms_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [3:0] quantity, [11:4] item_index,
                                       // [28:12] reading, [31:29] zero
  output logic             out_tlast
);

  localparam int AW = bms_pkg::ADDR_W;
  localparam int CW = bms_pkg::CNT_W;
  localparam int EW = bms_pkg::EXP_W;
  localparam int SW = bms_pkg::SENS_W;
  localparam int FB = bms_pkg::FRAME_BYTES;

  bms_pkg::state_t state_r, state_nxt;
  bms_pkg::phase_t phase_r, phase_nxt, kind_r, kind_nxt;
  bms_pkg::job_t   job_r, job_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt, n_r, n_nxt, cells_r, cells_nxt, cidx_r, cidx_nxt;
  logic [EW-1:0]  exp_r, exp_nxt;
  logic [7:0]     cmd_r, cmd_nxt, hi_r, hi_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [15:0]    sum_r, sum_nxt, word_r, word_nxt;
  logic [15:0]    lo_v_r, lo_v_nxt, hi_v_r, hi_v_nxt;
  logic [7:0]     lopos_r, lopos_nxt, hipos_r, hipos_nxt;
  logic [3:0]     step_r, step_nxt;
  logic [SW-1:0]  ntc_r, ntc_nxt, sidx_r, sidx_nxt;
  logic [31:0]    prod_r, prod_nxt;
  logic [3:0]     pq_r, pq_nxt;
  logic [7:0]     pidx_r, pidx_nxt;
  logic [16:0]    pval_r, pval_nxt;
  logic           plast_r, plast_nxt;
  logic           out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [3:0]     out_q_r, out_q_nxt;
  logic [7:0]     out_idx_r, out_idx_nxt;
  logic [16:0]    out_val_r, out_val_nxt;
  logic [FB-1:0]  valid_r, valid_nxt;
  logic           rd_valid_r;

  logic           in_accept, out_free, wr_en, overrun, frame_done;
  logic           sum_last, ck_ok, cell_last, temp_code, plain_code;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     ram_q, rd_byte, b;
  logic [CW-1:0]  cells_w;
  logic [12:0]    quot;

  assign b          = in_tdata;
  assign in_tready  = (state_r == bms_pkg::S_RX) && !out_valid_r;
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign rd_byte    = rd_valid_r ? ram_q : 8'd0;
  assign raddr      = (state_r == bms_pkg::S_WHI) ? ptr_r + AW'(1) : ptr_r;
  assign overrun    = (EW'(cnt_r) > exp_r) || (cnt_r >= CW'(FB));
  assign frame_done = in_accept && (phase_r != bms_pkg::P_IDLE) &&
                      (phase_r != bms_pkg::P_START) && !overrun &&
                      (b == bms_pkg::END_BYTE) && (EW'(cnt_r) == exp_r);
  assign sum_last   = ptr_r == AW'(n_r - CW'(4));
  assign ck_ok      = (word_r == 16'(16'd0 - sum_r)) && (sum_r != 16'd0);
  assign cells_w    = (n_r - CW'(7)) >> 1;
  assign cell_last  = (cidx_r + CW'(1)) == cells_r;
  assign temp_code  = bms_pkg::is_temp_code(cmd_r);
  assign plain_code = bms_pkg::is_plain_code(cmd_r);
  assign quot       = prod_r[bms_pkg::DIV10_SHIFT +: 13];

  bms_ram #(.WIDTH(8), .DEPTH(FB)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (b),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bms_pkg::S_RX:      if (frame_done) state_nxt = bms_pkg::S_SUM_RD;
      bms_pkg::S_SUM_RD:  state_nxt = bms_pkg::S_SUM_ACC;
      bms_pkg::S_SUM_ACC: state_nxt = sum_last ? bms_pkg::S_WHI_RD : bms_pkg::S_SUM_RD;
      bms_pkg::S_WHI_RD:  state_nxt = bms_pkg::S_WHI;
      bms_pkg::S_WHI:     state_nxt = bms_pkg::S_WLO;
      bms_pkg::S_WLO:     state_nxt = bms_pkg::S_ACT;
      bms_pkg::S_ACT: begin
        case (job_r)
          bms_pkg::J_CK: begin
            if (!ck_ok) begin
              state_nxt = bms_pkg::S_EMIT;
            end else if (kind_r == bms_pkg::P_STATUS) begin
              state_nxt = bms_pkg::S_WHI_RD;
            end else if (kind_r == bms_pkg::P_CELL) begin
              state_nxt = (cells_w == '0) ? bms_pkg::S_COUT : bms_pkg::S_WHI_RD;
            end else begin
              state_nxt = (temp_code || plain_code) ? bms_pkg::S_WHI_RD : bms_pkg::S_RX;
            end
          end
          bms_pkg::J_STAT:  state_nxt = bms_pkg::S_EMIT;
          bms_pkg::J_CELL:  state_nxt = cell_last ? bms_pkg::S_COUT : bms_pkg::S_WHI_RD;
          bms_pkg::J_PARAM: state_nxt = temp_code ? bms_pkg::S_MUL : bms_pkg::S_EMIT;
          default:          state_nxt = bms_pkg::S_RX;
        endcase
      end
      bms_pkg::S_MUL:  state_nxt = bms_pkg::S_DIV;
      bms_pkg::S_DIV:  state_nxt = bms_pkg::S_EMIT;
      bms_pkg::S_COUT: state_nxt = bms_pkg::S_EMIT;
      bms_pkg::S_EMIT: begin
        if (out_free) state_nxt = plast_r ? bms_pkg::S_RX : bms_pkg::S_NEXT;
      end
      bms_pkg::S_NEXT: begin
        state_nxt = (job_r == bms_pkg::J_COUT) ? bms_pkg::S_COUT : bms_pkg::S_WHI_RD;
      end
      default: state_nxt = bms_pkg::S_RX;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt = phase_r;  kind_nxt = kind_r;   job_nxt = job_r;
    cnt_nxt   = cnt_r;    n_nxt    = n_r;      cells_nxt = cells_r;
    cidx_nxt  = cidx_r;   exp_nxt  = exp_r;    cmd_nxt = cmd_r;
    hi_nxt    = hi_r;     ptr_nxt  = ptr_r;    sum_nxt = sum_r;
    word_nxt  = word_r;   lo_v_nxt = lo_v_r;   hi_v_nxt = hi_v_r;
    lopos_nxt = lopos_r;  hipos_nxt = hipos_r; step_nxt = step_r;
    ntc_nxt   = ntc_r;    sidx_nxt = sidx_r;   prod_nxt = prod_r;
    pq_nxt    = pq_r;     pidx_nxt = pidx_r;   pval_nxt = pval_r;
    plast_nxt = plast_r;  valid_nxt = valid_r;
    wr_en     = 1'b0;
    waddr     = cnt_r[AW-1:0];
    out_valid_nxt = out_valid_r && !out_tready;
    out_q_nxt = out_q_r;  out_idx_nxt = out_idx_r;
    out_val_nxt = out_val_r; out_last_nxt = out_last_r;

    case (state_r)
      bms_pkg::S_RX: begin
        if (in_accept) begin
          case (phase_r)
            bms_pkg::P_IDLE: begin
              if (b == bms_pkg::START_BYTE) begin
                wr_en     = 1'b1;
                waddr     = '0;
                cnt_nxt   = CW'(1);
                phase_nxt = bms_pkg::P_START;
              end
            end
            bms_pkg::P_START: begin
              if ((b inside {[bms_pkg::CMD_LOW:bms_pkg::CMD_HIGH]}) && cnt_r < CW'(FB)) begin
                wr_en     = 1'b1;
                cnt_nxt   = cnt_r + CW'(1);
                exp_nxt   = EW'(FB - 1);
                cmd_nxt   = b;
                phase_nxt = (b == bms_pkg::CMD_STATUS) ? bms_pkg::P_STATUS :
                            (b == bms_pkg::CMD_CELL)   ? bms_pkg::P_CELL : bms_pkg::P_PARAM;
              end else begin
                phase_nxt = bms_pkg::P_IDLE;
                cnt_nxt   = '0;
              end
            end
            default: begin
              if (overrun) begin
                // drop the byte and report the overrun
                phase_nxt     = bms_pkg::P_IDLE;
                cnt_nxt       = '0;
                out_valid_nxt = 1'b1;
                out_q_nxt     = bms_pkg::Q_OVERRUN;
                out_idx_nxt   = '0;
                out_val_nxt   = '0;
                out_last_nxt  = 1'b1;
              end else begin
                wr_en = 1'b1;
                if (frame_done) begin
                  n_nxt     = cnt_r + CW'(1);
                  kind_nxt  = phase_r;
                  phase_nxt = bms_pkg::P_IDLE;
                  cnt_nxt   = '0;
                  ptr_nxt   = AW'(2);
                  sum_nxt   = '0;
                end else begin
                  cnt_nxt = cnt_r + CW'(1);
                  if (cnt_r == CW'(3)) exp_nxt = EW'(b) + EW'(6);
                end
              end
            end
          endcase
        end
      end
      bms_pkg::S_SUM_ACC: begin
        sum_nxt = sum_r + 16'(rd_byte);
        if (sum_last) begin
          ptr_nxt = AW'(n_r - CW'(3));
          job_nxt = bms_pkg::J_CK;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      bms_pkg::S_WHI: hi_nxt   = rd_byte;
      bms_pkg::S_WLO: word_nxt = {hi_r, rd_byte};
      bms_pkg::S_ACT: begin
        case (job_r)
          bms_pkg::J_CK: begin
            if (!ck_ok) begin
              pq_nxt = bms_pkg::Q_CKERR; pidx_nxt = '0;
              pval_nxt = {1'b0, word_r}; plast_nxt = 1'b1;
            end else if (kind_r == bms_pkg::P_STATUS) begin
              job_nxt  = bms_pkg::J_STAT;
              step_nxt = '0;
              ptr_nxt  = bms_pkg::stat_addr(4'd0);
            end else if (kind_r == bms_pkg::P_CELL) begin
              cells_nxt = cells_w;
              cidx_nxt  = '0;
              lo_v_nxt  = bms_pkg::CELL_START;
              hi_v_nxt  = '0;
              ptr_nxt   = AW'(bms_pkg::DATA_BASE);
              job_nxt   = (cells_w == '0) ? bms_pkg::J_COUT : bms_pkg::J_CELL;
              step_nxt  = '0;
            end else begin
              job_nxt = bms_pkg::J_PARAM;
              ptr_nxt = AW'(bms_pkg::DATA_BASE);
            end
          end
          bms_pkg::J_STAT: begin
            pq_nxt = step_r; pidx_nxt = '0;
            pval_nxt = {1'b0, word_r}; plast_nxt = 1'b0;
            if (step_r == bms_pkg::STAT_CURR_STEP) begin
              pval_nxt = {word_r[15], word_r};
            end else if (step_r == bms_pkg::STAT_PCT_STEP ||
                         step_r == bms_pkg::STAT_CELL_STEP) begin
              pval_nxt = {9'd0, word_r[7:0]};
            end else if (step_r == bms_pkg::STAT_NTC_STEP) begin
              pval_nxt  = {9'd0, word_r[15:8]};
              ntc_nxt   = (word_r[15:8] > 8'(bms_pkg::MAX_SENSORS)) ?
                          SW'(bms_pkg::MAX_SENSORS) : SW'(word_r[15:8]);
              plast_nxt = word_r[15:8] == 8'd0;
            end else if (step_r == bms_pkg::STAT_TEMP_STEP) begin
              pq_nxt    = bms_pkg::Q_TEMP;
              pidx_nxt  = 8'(sidx_r);
              pval_nxt  = {1'b0, word_r} - bms_pkg::KELVIN_OFS;
              plast_nxt = (sidx_r + SW'(1)) == ntc_r;
            end
          end
          bms_pkg::J_CELL: begin
            if (word_r < lo_v_r) begin
              lo_v_nxt = word_r; lopos_nxt = 8'(cidx_r + CW'(1));
            end
            if (word_r > hi_v_r) begin
              hi_v_nxt = word_r; hipos_nxt = 8'(cidx_r + CW'(1));
            end
            cidx_nxt = cidx_r + CW'(1);
            ptr_nxt  = ptr_r + AW'(2);
            if (cell_last) begin
              job_nxt = bms_pkg::J_COUT; step_nxt = '0;
            end
          end
          bms_pkg::J_PARAM: begin
            prod_nxt = 32'(word_r) * 32'(bms_pkg::DIV10_MUL);
            pq_nxt = bms_pkg::Q_PARAM; pidx_nxt = cmd_r;
            pval_nxt = {1'b0, word_r}; plast_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      bms_pkg::S_DIV: begin
        // whole degrees minus 273.15, truncated toward zero
        if (quot >= 13'd274)      pval_nxt = {4'd0, quot} - 17'd274;
        else if (quot == 13'd273) pval_nxt = '0;
        else                      pval_nxt = {4'd0, quot} - 17'd273;
      end
      bms_pkg::S_COUT: begin
        pidx_nxt = '0; plast_nxt = 1'b0;
        case (step_r)
          4'd0: begin
            pq_nxt = bms_pkg::Q_LOW; pidx_nxt = lopos_r; pval_nxt = {1'b0, lo_v_r};
          end
          4'd1: begin
            pq_nxt = bms_pkg::Q_HIGH; pidx_nxt = hipos_r; pval_nxt = {1'b0, hi_v_r};
          end
          4'd2: begin
            pq_nxt = bms_pkg::Q_DELTA; pval_nxt = {1'b0, hi_v_r} - {1'b0, lo_v_r};
          end
          default: begin
            pq_nxt = bms_pkg::Q_CELLS; pval_nxt = 17'(cells_r); plast_nxt = 1'b1;
          end
        endcase
      end
      bms_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = pq_r;
          out_idx_nxt   = pidx_r;
          out_val_nxt   = pval_r;
          out_last_nxt  = plast_r;
        end
      end
      bms_pkg::S_NEXT: begin
        if (job_r == bms_pkg::J_COUT) begin
          step_nxt = step_r + 4'd1;
        end else if (step_r == bms_pkg::STAT_NTC_STEP) begin
          step_nxt = bms_pkg::STAT_TEMP_STEP;
          sidx_nxt = '0;
          ptr_nxt  = AW'(bms_pkg::TEMP_BASE);
        end else if (step_r == bms_pkg::STAT_TEMP_STEP) begin
          sidx_nxt = sidx_r + SW'(1);
          ptr_nxt  = ptr_r + AW'(2);
        end else begin
          step_nxt = step_r + 4'd1;
          ptr_nxt  = bms_pkg::stat_addr(step_r + 4'd1);
        end
      end
      default: ;
    endcase

    if (wr_en) valid_nxt[waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bms_pkg::S_RX;
      phase_r     <= bms_pkg::P_IDLE;
      cnt_r       <= '0;
      exp_r       <= '0;
      lopos_r     <= '0;
      hipos_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      exp_r       <= exp_nxt;
      lopos_r     <= lopos_nxt;
      hipos_r     <= hipos_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;   job_r <= job_nxt;     n_r <= n_nxt;
    cells_r <= cells_nxt; cidx_r <= cidx_nxt;   cmd_r <= cmd_nxt;
    hi_r <= hi_nxt;       ptr_r <= ptr_nxt;     sum_r <= sum_nxt;
    word_r <= word_nxt;   lo_v_r <= lo_v_nxt;   hi_v_r <= hi_v_nxt;
    step_r <= step_nxt;   ntc_r <= ntc_nxt;     sidx_r <= sidx_nxt;
    prod_r <= prod_nxt;   pq_r <= pq_nxt;       pidx_r <= pidx_nxt;
    pval_r <= pval_nxt;   plast_r <= plast_nxt;
    out_q_r <= out_q_nxt; out_idx_r <= out_idx_nxt;
    out_val_r <= out_val_nxt; out_last_r <= out_last_nxt;
    rd_valid_r <= valid_r[raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'd0, out_val_r, out_idx_r, out_q_r};

endmodule

`default_nettype wire
